// File: sv/bb3_pkg.sv
package bb3_pkg;

  localparam int ChanW        = 8;
  localparam int SumW         = 12;
  localparam int CntW         = 4;
  localparam int RecipW       = 17;
  localparam int RecipShift   = 16;
  localparam int LineWidthW   = 11;
  localparam int FrameHeightW = 16;
  localparam int CfgIdxW      = 1;
  localparam int CfgDataW     = 16;

  localparam logic [CfgIdxW-1:0] CfgLineWidth   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 1'b1;

  localparam logic [LineWidthW-1:0]   LineWidthRst   = 11'd640;
  localparam logic [FrameHeightW-1:0] FrameHeightRst = 16'd480;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic             end_of_line;
    logic             end_of_frame;
  } result_t;

  // floor(2^16 / cnt) for the neighbor counts a 3x3 window can have
  function automatic logic [RecipW-1:0] recip_f(input logic [CntW-1:0] cnt);
    logic [RecipW-1:0] m;
    unique case (cnt)
      4'd2:    m = 17'd32768;
      4'd3:    m = 17'd21845;
      4'd4:    m = 17'd16384;
      4'd6:    m = 17'd10922;
      4'd9:    m = 17'd7281;
      default: m = 17'd65536;
    endcase
    return m;
  endfunction

endpackage

// File: sv/bb3_if.sv
interface bb3_in_if;
  logic                     valid;
  logic                     ready;
  logic [bb3_pkg::ChanW-1:0] red;
  logic [bb3_pkg::ChanW-1:0] green;
  logic [bb3_pkg::ChanW-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface bb3_out_if;
  logic                     valid;
  logic                     ready;
  logic [bb3_pkg::ChanW-1:0] out_red;
  logic [bb3_pkg::ChanW-1:0] out_green;
  logic [bb3_pkg::ChanW-1:0] out_blue;
  logic                     end_of_line;
  logic                     end_of_frame;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output end_of_line, output end_of_frame, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input end_of_line, input end_of_frame, output ready);
endinterface

// File: sv/box_blur_3x3_edge_aware.sv
// Channel    Dir  Moves                      Payload
// pix_i      in   one request per pixel      red, green, blue
// res_o      out  one request per result     out_red/green/blue, end_of_line, end_of_frame
// cfg_*      in   register write, no wait    index 0 line_width, index 1 frame_height
//
// Each accepted pixel goes through the line store read-modify-write (read at
// accept, write back in the read step), then releases n = 0..4 results, each
// through a sum / reciprocal-multiply / correct sequence; a result waits in its
// correct step until the output register drains, and a new pixel waits for all.
// Reset clears control state and the window columns; the line stores are never
// cleared, since entries outside the frame are masked off and never reach a result.
// A stall on res_o holds the sequencer in its correct step; the last result of
// a pixel may still sit in the output register while the next pixel is taken.
module box_blur_3x3_edge_aware #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bb3_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bb3_pkg::CfgDataW-1:0] cfg_wdata_i,
  bb3_in_if.sink                       pix_i,
  bb3_out_if.source                    res_o
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW = ($clog2(MAX_WIDTH + 1) > bb3_pkg::LineWidthW) ?
                      $clog2(MAX_WIDTH + 1) : bb3_pkg::LineWidthW;
  localparam logic [EW-1:0] MaxW = EW'(MAX_WIDTH);
  localparam int SW = bb3_pkg::SumW;
  localparam int CW = bb3_pkg::CntW;
  localparam int PW = bb3_pkg::SumW + bb3_pkg::RecipW;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_SUM  = 5'b00100,
    S_MUL  = 5'b01000,
    S_FIX  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration and effective frame size
  logic [bb3_pkg::LineWidthW-1:0]   lw_q;
  logic [bb3_pkg::FrameHeightW-1:0] fh_q;
  logic [EW-1:0]                    lw_ext, eff_w;
  logic [bb3_pkg::FrameHeightW-1:0] eff_h;

  assign lw_ext = EW'(lw_q);
  assign eff_w  = (lw_q == '0) ? EW'(1) : ((lw_ext > MaxW) ? MaxW : lw_ext);
  assign eff_h  = (fh_q == '0) ? bb3_pkg::FrameHeightW'(1) : fh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q <= bb3_pkg::LineWidthRst;
      fh_q <= bb3_pkg::FrameHeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bb3_pkg::CfgLineWidth:   lw_q <= cfg_wdata_i[bb3_pkg::LineWidthW-1:0];
        bb3_pkg::CfgFrameHeight: fh_q <= cfg_wdata_i;
      endcase
    end
  end

  // position of the next pixel
  logic [AW-1:0]                    x_q;
  logic [bb3_pkg::FrameHeightW-1:0] r_q;
  logic                             last_col, last_row;

  assign last_col = (EW'(x_q) == eff_w - EW'(1));
  assign last_row = (r_q == eff_h - bb3_pkg::FrameHeightW'(1));

  logic acc;
  assign pix_i.ready = (state_q == S_IDLE);
  assign acc         = pix_i.valid && pix_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      r_q <= '0;
    end else begin
      priority if (cfg_we_i) begin
        // any register write restarts the frame
        x_q <= '0;
        r_q <= '0;
      end else if (state_q == S_RD) begin
        if (last_col) begin
          x_q <= '0;
          r_q <= last_row ? '0 : r_q + bb3_pkg::FrameHeightW'(1);
        end else begin
          x_q <= x_q + AW'(1);
        end
      end
    end
  end

  // line stores: read at accept, written back in the store read step that follows, at the same column
  bb3_pkg::pixel_t upper_mem  [MAX_WIDTH];
  bb3_pkg::pixel_t middle_mem [MAX_WIDTH];
  bb3_pkg::pixel_t up_rd_q, mid_rd_q, px_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD) begin
      upper_mem[x_q]  <= mid_rd_q;
      middle_mem[x_q] <= px_q;
    end
    if (acc) begin
      up_rd_q  <= upper_mem[x_q];
      mid_rd_q <= middle_mem[x_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      px_q <= '{red: pix_i.red, green: pix_i.green, blue: pix_i.blue};
    end
  end

  // window: two older columns held in flops, newest column from the store reads and the new pixel
  bb3_pkg::pixel_t wc_q  [6];
  bb3_pkg::pixel_t win_q [9];
  logic            xg1_q, xg2_q, rg1_q, rg2_q;
  logic [3:0]      pend_q, pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) wc_q[i] <= '0;
    end else if (state_q == S_RD) begin
      wc_q[0] <= wc_q[1];
      wc_q[1] <= up_rd_q;
      wc_q[2] <= wc_q[3];
      wc_q[3] <= mid_rd_q;
      wc_q[4] <= wc_q[5];
      wc_q[5] <= px_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD) begin
      win_q[0] <= wc_q[0];
      win_q[1] <= wc_q[1];
      win_q[2] <= up_rd_q;
      win_q[3] <= wc_q[2];
      win_q[4] <= wc_q[3];
      win_q[5] <= mid_rd_q;
      win_q[6] <= wc_q[4];
      win_q[7] <= wc_q[5];
      win_q[8] <= px_q;
      xg1_q    <= (x_q != '0);
      xg2_q    <= (x_q > AW'(1));
      rg1_q    <= (r_q != '0);
      rg2_q    <= (r_q > bb3_pkg::FrameHeightW'(1));
    end
  end

  // result selection: lowest pending slot first, which is the emit order
  // slot 0: center above-left, slot 1: last row left, slot 2: row above at
  // the right edge, slot 3: last row at the right edge
  logic [1:0] sel, sel_q;
  logic       cr2, cc2;
  logic [2:0] rm, cm;

  always_comb begin
    priority if (pend_q[0]) sel = 2'd0;
    else if (pend_q[1])     sel = 2'd1;
    else if (pend_q[2])     sel = 2'd2;
    else                    sel = 2'd3;
  end

  assign cr2 = sel[0];
  assign cc2 = sel[1];
  assign rm  = cr2 ? {1'b1, rg1_q, 1'b0} : {1'b1, 1'b1, rg2_q};
  assign cm  = cc2 ? {1'b1, xg1_q, 1'b0} : {1'b1, 1'b1, xg2_q};

  // sum stage
  logic [SW-1:0] s_r, s_g, s_b;
  logic [CW-1:0] cnt;

  always_comb begin
    s_r = '0;
    s_g = '0;
    s_b = '0;
    cnt = '0;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        if (rm[k] && cm[j]) begin
          s_r = s_r + SW'(win_q[3*k+j].red);
          s_g = s_g + SW'(win_q[3*k+j].green);
          s_b = s_b + SW'(win_q[3*k+j].blue);
          cnt = cnt + CW'(1);
        end
      end
    end
  end

  // (2s+c)/(2c) equals (s + c/2)/c for integer s and c
  logic [SW-1:0] t_q [3];
  logic [CW-1:0] cnt_q;
  logic          eol_q, eof_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_SUM) begin
      t_q[0] <= s_r + SW'(cnt >> 1);
      t_q[1] <= s_g + SW'(cnt >> 1);
      t_q[2] <= s_b + SW'(cnt >> 1);
      cnt_q  <= cnt;
      eol_q  <= cc2;
      eof_q  <= (sel == 2'd3);
      sel_q  <= sel;
    end
  end

  // reciprocal multiply: estimate is the quotient or one below it
  logic [bb3_pkg::RecipW-1:0] recip;
  logic [PW-1:0]              prod [3];
  logic [bb3_pkg::ChanW-1:0]  q0_q [3];

  assign recip = bb3_pkg::recip_f(cnt_q);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = PW'(t_q[c]) * PW'(recip);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL) begin
      for (int c = 0; c < 3; c++) begin
        q0_q[c] <= prod[c][bb3_pkg::RecipShift +: bb3_pkg::ChanW];
      end
    end
  end

  // correction: bump the estimate when the remainder reaches the count
  logic [bb3_pkg::ChanW-1:0] q [3];
  logic [SW-1:0]             rem [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rem[c] = t_q[c] - SW'(q0_q[c]) * SW'(cnt_q);
      q[c]   = (rem[c] >= SW'(cnt_q)) ? q0_q[c] + bb3_pkg::ChanW'(1) : q0_q[c];
    end
  end

  // output register
  logic            out_valid_q, out_load;
  bb3_pkg::result_t out_q;

  assign out_load = (state_q == S_FIX) && (!out_valid_q || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= '{out_red: q[0], out_green: q[1], out_blue: q[2],
                 end_of_line: eol_q, end_of_frame: eof_q};
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.out_red      = out_q.out_red;
  assign res_o.out_green    = out_q.out_green;
  assign res_o.out_blue     = out_q.out_blue;
  assign res_o.end_of_line  = out_q.end_of_line;
  assign res_o.end_of_frame = out_q.end_of_frame;

  // sequencer
  logic [3:0] rd_pend, pend_left;

  assign rd_pend = {last_col && last_row, last_col && (r_q != '0),
                    last_row && (x_q != '0), (r_q != '0) && (x_q != '0)};

  always_comb begin
    pend_left          = pend_q;
    pend_left[sel_q]   = 1'b0;
    state_d            = state_q;
    pend_d             = pend_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc) state_d = S_RD;
      end
      S_RD: begin
        pend_d  = rd_pend;
        state_d = (rd_pend != '0) ? S_SUM : S_IDLE;
      end
      S_SUM: state_d = S_MUL;
      S_MUL: state_d = S_FIX;
      S_FIX: begin
        // hold here until the output register frees up
        if (out_load) begin
          pend_d  = pend_left;
          state_d = (pend_left != '0) ? S_SUM : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  // checks
  a_acc_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> (state_q == S_RD))
    else $error("accepted pixel did not enter the store read step");

  a_busy_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM || state_q == S_MUL || state_q == S_FIX) |-> (pend_q != '0))
    else $error("result sequencer running with nothing pending");

  a_eof_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.end_of_frame) |-> res_o.end_of_line)
    else $error("frame end flagged on a pixel that is not a row end");

  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (x_q == '0 && r_q == '0))
    else $error("register write did not restart the frame");

  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (cnt_q != '0))
    else $error("neighbor count is zero at the divide step");

endmodule
